FILE: hdl/rotation_matrix_to_quaternion_assert.svh
// Assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// same-cycle implication
`define RMQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rmq assertion failed");

// next-cycle implication
`define RMQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rmq assertion failed");

`endif

FILE: hdl/rmq_pkg.sv
// Package: widths and lane types for the rotation matrix to quaternion block
package rmq_pkg;
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;
   localparam int QW         = DATA_WIDTH + 3;          // signed raw component
   localparam int MW         = DATA_WIDTH + 2;          // raw magnitude
   localparam int NW         = 30;                      // normalised magnitude
   localparam int NMSB       = NW - 1;
   localparam int PW         = 2 * NW;                  // square
   localparam int SW         = PW + 2;                  // sum of four squares
   localparam int RW         = SW / 2;                  // root
   localparam int REMW       = RW + 2;                  // root remainder
   localparam int SQ_STAGES  = RW;
   localparam int QB         = DATA_WIDTH;              // quotient bits
   localparam int DW         = NW + FRAC_BITS + 1;      // dividend
   localparam int DIV_STAGES = QB;
   localparam int SHW        = 5;
   localparam int LANES      = 4;                       // w, x, y, z
   localparam logic signed [QW-1:0] ONE = QW'(1) <<< FRAC_BITS;
   localparam logic [QB:0] POS_MAX = (QB+1)'((1 << (DATA_WIDTH - 1)) - 1);
   localparam logic [QB:0] NEG_MAX = (QB+1)'(1 << (DATA_WIDTH - 1));

   typedef logic [LANES-1:0][MW-1:0]  raw_mag_type;
   typedef logic [LANES-1:0][NW-1:0]  norm_mag_type;
   typedef logic [LANES-1:0][PW-1:0]  square_type;
   typedef logic [LANES-1:0][DW-1:0]  div_rem_type;
   typedef logic [LANES-1:0][QB-1:0]  quot_type;
   typedef logic [LANES-1:0]          sign_type;
endpackage

FILE: hdl/rotation_matrix_to_quaternion.sv
// Top level: pipelined rotation matrix to unit quaternion converter
// A request passes the front stages, the square root, the divider and the output register.
// Throughput: one request per cycle while the output is not stalled; the 31-stage root and
// 16-stage divider each retire one bit per stage, so every stage takes a new request each cycle.
// A stalled result holds; bubbles ahead of it close up so requests keep entering.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
module rotation_matrix_to_quaternion (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [rmq_pkg::DATA_WIDTH-1:0] req_m00,
   input  logic signed [rmq_pkg::DATA_WIDTH-1:0] req_m01,
   input  logic signed [rmq_pkg::DATA_WIDTH-1:0] req_m02,
   input  logic signed [rmq_pkg::DATA_WIDTH-1:0] req_m10,
   input  logic signed [rmq_pkg::DATA_WIDTH-1:0] req_m11,
   input  logic signed [rmq_pkg::DATA_WIDTH-1:0] req_m12,
   input  logic signed [rmq_pkg::DATA_WIDTH-1:0] req_m20,
   input  logic signed [rmq_pkg::DATA_WIDTH-1:0] req_m21,
   input  logic signed [rmq_pkg::DATA_WIDTH-1:0] req_m22,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [rmq_pkg::DATA_WIDTH-1:0] rsp_qw,
   output logic signed [rmq_pkg::DATA_WIDTH-1:0] rsp_qx,
   output logic signed [rmq_pkg::DATA_WIDTH-1:0] rsp_qy,
   output logic signed [rmq_pkg::DATA_WIDTH-1:0] rsp_qz
);
   import rmq_pkg::*;

   // ---------------- stage 1: raw components ----------------
   logic signed [QW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
   logic signed [QW-1:0] tr, dd;
   logic signed [QW-1:0] q_in [LANES];
   logic [1:0] sel;
   raw_mag_type mag1_in;
   sign_type neg1_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
   raw_mag_type mag1_ff, mag2_ff;
   sign_type neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic [MW-1:0] mx2_ff;
   norm_mag_type mag3_ff, mag4_ff, mag5_ff;
   logic [NW-1:0] mx3_ff;
   logic z3_ff, z4_ff, z5_ff;
   square_type sq4_ff;
   logic [SW-1:0] s5_ff;

   always_comb begin
      a00 = QW'(req_m00); a01 = QW'(req_m01); a02 = QW'(req_m02);
      a10 = QW'(req_m10); a11 = QW'(req_m11); a12 = QW'(req_m12);
      a20 = QW'(req_m20); a21 = QW'(req_m21); a22 = QW'(req_m22);
      tr = a00 + a11 + a22;
      sel = 2'd0;
      if (a11 > a00) sel = 2'd1;
      if (a22 > ((sel == 2'd1) ? a11 : a00)) sel = 2'd2;
      dd = '0;
      for (int l = 0; l < LANES; l++) q_in[l] = '0;
      if (tr > 0) begin
         q_in[0] = tr + ONE;
         q_in[1] = a21 - a12;
         q_in[2] = a02 - a20;
         q_in[3] = a10 - a01;
      end else begin
         unique case (sel)
            2'd1: begin
               dd = a11 - (a22 + a00) + ONE;
               q_in[2] = dd;
               q_in[3] = a12 + a21;
               q_in[1] = a10 + a01;
               q_in[0] = a02 - a20;
            end
            2'd2: begin
               dd = a22 - (a00 + a11) + ONE;
               q_in[3] = dd;
               q_in[1] = a20 + a02;
               q_in[2] = a21 + a12;
               q_in[0] = a10 - a01;
            end
            default: begin
               dd = a00 - (a11 + a22) + ONE;
               q_in[1] = dd;
               q_in[2] = a01 + a10;
               q_in[3] = a02 + a20;
               q_in[0] = a21 - a12;
            end
         endcase
         if (dd <= 0) begin
            for (int l = 0; l < LANES; l++) q_in[l] = '0;
         end
      end
      for (int l = 0; l < LANES; l++) begin
         neg1_in[l] = q_in[l] < 0;
         mag1_in[l] = neg1_in[l] ? MW'(-q_in[l]) : MW'(q_in[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (rdy1) v1_ff <= req_valid;
      if (rdy1) begin
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
      end
   end

   // ---------------- stage 2: largest magnitude ----------------
   logic [MW-1:0] mx01, mx23, mx2_in;
   always_comb begin
      mx01 = (mag1_ff[0] > mag1_ff[1]) ? mag1_ff[0] : mag1_ff[1];
      mx23 = (mag1_ff[2] > mag1_ff[3]) ? mag1_ff[2] : mag1_ff[3];
      mx2_in = (mx01 > mx23) ? mx01 : mx23;
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (rdy2) v2_ff <= v1_ff;
      if (rdy2) begin
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         mx2_ff  <= mx2_in;
      end
   end

   // ---------------- stage 3: normalising shift ----------------
   logic [SHW-1:0] msb, sh;
   always_comb begin
      msb = '0;
      for (int b = 0; b < MW; b++) begin
         if (mx2_ff[b]) msb = SHW'(b);
      end
      sh = SHW'(NMSB) - msb;
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (rdy3) v3_ff <= v2_ff;
      if (rdy3) begin
         for (int l = 0; l < LANES; l++) mag3_ff[l] <= NW'(mag2_ff[l]) << sh;
         mx3_ff  <= NW'(mx2_ff) << sh;
         neg3_ff <= neg2_ff;
         z3_ff   <= (mx2_ff == '0);
      end
   end

   // ---------------- stage 4: squares ----------------
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (rdy4) v4_ff <= v3_ff;
      if (rdy4) begin
         for (int l = 0; l < LANES; l++) sq4_ff[l] <= mag3_ff[l] * mag3_ff[l];
         mag4_ff <= mag3_ff;
         neg4_ff <= neg3_ff;
         z4_ff   <= z3_ff;
      end
   end

   // ---------------- stage 5: sum of squares ----------------
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (rdy5) v5_ff <= v4_ff;
      if (rdy5) begin
         s5_ff <= SW'(sq4_ff[0]) + SW'(sq4_ff[1]) + SW'(sq4_ff[2]) + SW'(sq4_ff[3]);
         mag5_ff <= mag4_ff;
         neg5_ff <= neg4_ff;
         z5_ff   <= z4_ff;
      end
   end

   // ---------------- square root: one root bit per stage ----------------
   logic                sv_ff    [SQ_STAGES];
   logic [REMW-1:0]     srem_ff  [SQ_STAGES];
   logic [RW-1:0]       sroot_ff [SQ_STAGES];
   logic [SW-1:0]       ssrc_ff  [SQ_STAGES];
   norm_mag_type        smag_ff  [SQ_STAGES];
   sign_type            sneg_ff  [SQ_STAGES];
   logic                sz_ff    [SQ_STAGES];
   logic                srdy     [SQ_STAGES];

   logic                dv_ff    [DIV_STAGES];
   div_rem_type         drem_ff  [DIV_STAGES];
   quot_type            dq_ff    [DIV_STAGES];
   logic [RW-1:0]       dlen_ff  [DIV_STAGES];
   sign_type            dneg_ff  [DIV_STAGES];
   logic                dz_ff    [DIV_STAGES];
   logic                drdy     [DIV_STAGES];

   for (genvar n = 0; n < SQ_STAGES; n++) begin : g_sqrt
      logic                 v_prev, z_prev;
      logic [REMW-1:0]      rem_prev;
      logic [RW-1:0]        root_prev;
      logic [SW-1:0]        src_prev;
      norm_mag_type         mag_prev;
      sign_type             neg_prev;
      logic [REMW+1:0]      rem_w, trial;

      if (n == 0) begin : g_first
         assign v_prev    = v5_ff;
         assign z_prev    = z5_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign src_prev  = s5_ff;
         assign mag_prev  = mag5_ff;
         assign neg_prev  = neg5_ff;
      end else begin : g_next
         assign v_prev    = sv_ff[n-1];
         assign z_prev    = sz_ff[n-1];
         assign rem_prev  = srem_ff[n-1];
         assign root_prev = sroot_ff[n-1];
         assign src_prev  = ssrc_ff[n-1];
         assign mag_prev  = smag_ff[n-1];
         assign neg_prev  = sneg_ff[n-1];
      end

      assign rem_w = {rem_prev, src_prev[SW-1:SW-2]};
      assign trial = {2'b00, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) sv_ff[n] <= 1'b0;
         else if (srdy[n]) sv_ff[n] <= v_prev;
         if (srdy[n]) begin
            if (rem_w >= trial) begin
               srem_ff[n]  <= REMW'(rem_w - trial);
               sroot_ff[n] <= {root_prev[RW-2:0], 1'b1};
            end else begin
               srem_ff[n]  <= REMW'(rem_w);
               sroot_ff[n] <= {root_prev[RW-2:0], 1'b0};
            end
            ssrc_ff[n] <= src_prev << 2;
            smag_ff[n] <= mag_prev;
            sneg_ff[n] <= neg_prev;
            sz_ff[n]   <= z_prev;
         end
      end
   end

   // ---------------- divider: one quotient bit per stage ----------------
   for (genvar n = 0; n < DIV_STAGES; n++) begin : g_div
      logic                 v_prev, z_prev;
      div_rem_type          rem_prev;
      quot_type             q_prev;
      logic [RW-1:0]        len_prev;
      sign_type             neg_prev;
      logic [DW:0]          dsub;

      if (n == 0) begin : g_first
         assign v_prev   = sv_ff[SQ_STAGES-1];
         assign z_prev   = sz_ff[SQ_STAGES-1];
         assign len_prev = sroot_ff[SQ_STAGES-1];
         assign neg_prev = sneg_ff[SQ_STAGES-1];
         assign q_prev   = '0;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_prev[l] = (DW'(smag_ff[SQ_STAGES-1][l]) << FRAC_BITS)
                                 + DW'(sroot_ff[SQ_STAGES-1] >> 1);
         end
      end else begin : g_next
         assign v_prev   = dv_ff[n-1];
         assign z_prev   = dz_ff[n-1];
         assign len_prev = dlen_ff[n-1];
         assign neg_prev = dneg_ff[n-1];
         assign q_prev   = dq_ff[n-1];
         assign rem_prev = drem_ff[n-1];
      end

      assign dsub = (DW+1)'(len_prev) << (DIV_STAGES - 1 - n);

      always_ff @(posedge clock) begin
         if (reset) dv_ff[n] <= 1'b0;
         else if (drdy[n]) dv_ff[n] <= v_prev;
         if (drdy[n]) begin
            for (int l = 0; l < LANES; l++) begin
               if ({1'b0, rem_prev[l]} >= dsub) begin
                  drem_ff[n][l] <= rem_prev[l] - DW'(dsub);
                  dq_ff[n][l]   <= {q_prev[l][QB-2:0], 1'b1};
               end else begin
                  drem_ff[n][l] <= rem_prev[l];
                  dq_ff[n][l]   <= {q_prev[l][QB-2:0], 1'b0};
               end
            end
            dlen_ff[n] <= len_prev;
            dneg_ff[n] <= neg_prev;
            dz_ff[n]   <= z_prev;
         end
      end
   end

   // ---------------- output: sign and saturation ----------------
   logic signed [DATA_WIDTH-1:0] res_in [LANES];
   logic signed [DATA_WIDTH-1:0] res_ff [LANES];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         logic [QB:0] qv;
         qv = {1'b0, dq_ff[DIV_STAGES-1][l]};
         if (dz_ff[DIV_STAGES-1]) res_in[l] = '0;
         else if (!dneg_ff[DIV_STAGES-1][l])
            res_in[l] = (qv > POS_MAX) ? DATA_WIDTH'(POS_MAX) : DATA_WIDTH'(qv);
         else
            res_in[l] = (qv > NEG_MAX) ? DATA_WIDTH'(NEG_MAX) : DATA_WIDTH'(-qv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rdy_out) rsp_valid_ff <= dv_ff[DIV_STAGES-1];
      if (rdy_out) begin
         for (int l = 0; l < LANES; l++) res_ff[l] <= res_in[l];
      end
   end

   // ---------------- advance chain: a stage moves when empty or drained ----------------
   always_comb begin
      rdy_out = !rsp_valid_ff || !rsp_stall;
      drdy[DIV_STAGES-1] = !dv_ff[DIV_STAGES-1] || rdy_out;
      for (int n = DIV_STAGES - 2; n >= 0; n--) drdy[n] = !dv_ff[n] || drdy[n+1];
      srdy[SQ_STAGES-1] = !sv_ff[SQ_STAGES-1] || drdy[0];
      for (int n = SQ_STAGES - 2; n >= 0; n--) srdy[n] = !sv_ff[n] || srdy[n+1];
      rdy5 = !v5_ff || srdy[0];
      rdy4 = !v4_ff || rdy5;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
   end

   assign req_stall = !rdy1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_qw    = res_ff[0];
   assign rsp_qx    = res_ff[1];
   assign rsp_qy    = res_ff[2];
   assign rsp_qz    = res_ff[3];

`include "rotation_matrix_to_quaternion_assert.svh"

   `RMQ_ASSERT_NOW(a_norm_range, v3_ff && !z3_ff, mx3_ff[NMSB])
   `RMQ_ASSERT_NOW(a_root_floor, sv_ff[SQ_STAGES-1] && !sz_ff[SQ_STAGES-1],
      sroot_ff[SQ_STAGES-1][RW-1:NMSB] != '0)
   `RMQ_ASSERT_NEXT(a_out_hold, rsp_valid_ff && rsp_stall,
      rsp_valid_ff && $stable({res_ff[0], res_ff[1], res_ff[2], res_ff[3]}))
endmodule
